// ----- src/mer_pkg.sv -----
package mer_pkg;

  // Datapath commands, one per cycle, issued by the controller
  typedef enum logic [4:0] {
    OP_NOP,
    OP_LOAD,
    OP_SQ_RY,
    OP_RXRY,
    OP_DEC0,
    OP_R1_MX,
    OP_R1_MY,
    OP_R1_CMP,
    OP_R1_UPD,
    OP_R1_FIN,
    OP_T_TX2,
    OP_T_RYTX,
    OP_T_TY2,
    OP_T_RXTY,
    OP_T_RXRY,
    OP_T_FIN,
    OP_R2_STEP,
    OP_R2_UPD,
    OP_R2_FIN,
    OP_EMIT,
    OP_EMIT_NULL
  } mer_op_t;

  // Datapath status seen by the controller
  typedef struct packed {
    logic busy;        // an ellipse is being walked
    logic region_two;  // walk has left region 1
    logic lt;          // ry2*x < rx2*y, valid in the compare cycle
  } mer_status_t;

endpackage

// ----- src/midpoint_ellipse_rasterizer_top.sv -----
// Midpoint ellipse rasterizer: one result transaction per input transaction.
// A new input is taken only while idle, after the result for the previous one has been
// emitted; the single shared multiplier yields one registered product per cycle. Each input
// is a start, a region-1 step, a region-2 step, the step that crosses into region 2, or an idle advance.
// A stalled output holds the previous result and delays the next emit.
// Synchronous active-low reset: idle, no ellipse in progress, output empty.
module midpoint_ellipse_rasterizer_top #(
  parameter int COORD_BITS  = 10,
  parameter int RADIUS_BITS = 9
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  // center_x, center_y, radius_x, radius_y, zero pad
  input  logic [((2*COORD_BITS+2*RADIUS_BITS+7)/8)*8-1:0] in_tdata,
  // action
  input  logic in_tuser,
  output logic out_tvalid,
  input  logic out_tready,
  // px_pp, py_pp, px_mp, py_mp, px_pm, py_pm, px_mm, py_mm, zero pad
  output logic [((8*(COORD_BITS+2)+7)/8)*8-1:0] out_tdata,
  // valid_res
  output logic out_tuser,
  output logic out_tlast
);

  localparam int PIX_W       = COORD_BITS + 2;
  localparam int OUT_TDATA_W = ((8*PIX_W+7)/8)*8;
  localparam int CX_LO       = 0;
  localparam int CY_LO       = COORD_BITS;
  localparam int RX_LO       = 2 * COORD_BITS;
  localparam int RY_LO       = 2 * COORD_BITS + RADIUS_BITS;

  mer_pkg::mer_status_t status;
  mer_pkg::mer_op_t     op;
  logic                 res_valid;
  logic                 res_last;
  logic [8*PIX_W-1:0]   res_pix;

  mer_datapath #(
    .COORD_BITS  (COORD_BITS),
    .RADIUS_BITS (RADIUS_BITS),
    .PIX_W       (PIX_W)
  ) u_datapath (
    .clk         (clk),
    .rst_n       (rst_n),
    .op          (op),
    .in_center_x (in_tdata[CX_LO +: COORD_BITS]),
    .in_center_y (in_tdata[CY_LO +: COORD_BITS]),
    .in_radius_x (in_tdata[RX_LO +: RADIUS_BITS]),
    .in_radius_y (in_tdata[RY_LO +: RADIUS_BITS]),
    .status      (status),
    .res_valid   (res_valid),
    .res_last    (res_last),
    .res_pix     (res_pix)
  );

  mer_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_action  (in_tuser),
    .in_tready  (in_tready),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .status     (status),
    .op         (op)
  );

  // Pack the result transaction
  assign out_tdata = OUT_TDATA_W'(res_pix);
  assign out_tuser = res_valid;
  assign out_tlast = res_last;

endmodule

// ----- src/mer_ctrl.sv -----
module mer_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  input  logic                 in_action,
  output logic                 in_tready,
  input  logic                 out_tready,
  output logic                 out_tvalid,
  input  mer_pkg::mer_status_t status,
  output mer_pkg::mer_op_t     op
);

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_SQ_RY,
    ST_RXRY,
    ST_DEC0,
    ST_R1_MY,
    ST_R1_CMP,
    ST_R1_UPD,
    ST_R1_FIN,
    ST_T_TX2,
    ST_T_RYTX,
    ST_T_TY2,
    ST_T_RXTY,
    ST_T_RXRY,
    ST_T_FIN,
    ST_R2_STEP,
    ST_R2_UPD,
    ST_R2_FIN,
    ST_EMIT,
    ST_EMIT_NULL
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   out_valid_r;
  logic   out_valid_nxt;
  logic   out_free;
  logic   emit;

  assign out_free   = !out_valid_r || out_tready;
  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;

  // Sequence the datapath: one command per cycle
  always_comb begin
    state_nxt = state_r;
    op        = mer_pkg::OP_NOP;
    emit      = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          if (!in_action) begin
            op        = mer_pkg::OP_LOAD;
            state_nxt = ST_SQ_RY;
          end else if (!status.busy) begin
            state_nxt = ST_EMIT_NULL;
          end else if (status.region_two) begin
            op        = mer_pkg::OP_R2_STEP;
            state_nxt = ST_R2_UPD;
          end else begin
            op        = mer_pkg::OP_R1_MX;
            state_nxt = ST_R1_MY;
          end
        end
      end
      ST_SQ_RY: begin
        op        = mer_pkg::OP_SQ_RY;
        state_nxt = ST_RXRY;
      end
      ST_RXRY: begin
        op        = mer_pkg::OP_RXRY;
        state_nxt = ST_DEC0;
      end
      ST_DEC0: begin
        op        = mer_pkg::OP_DEC0;
        state_nxt = ST_EMIT;
      end
      ST_R1_MY: begin
        op        = mer_pkg::OP_R1_MY;
        state_nxt = ST_R1_CMP;
      end
      ST_R1_CMP: begin
        op        = mer_pkg::OP_R1_CMP;
        state_nxt = status.lt ? ST_R1_UPD : ST_T_TX2;
      end
      ST_R1_UPD: begin
        op        = mer_pkg::OP_R1_UPD;
        state_nxt = ST_R1_FIN;
      end
      ST_R1_FIN: begin
        op        = mer_pkg::OP_R1_FIN;
        state_nxt = ST_EMIT;
      end
      ST_T_TX2: begin
        op        = mer_pkg::OP_T_TX2;
        state_nxt = ST_T_RYTX;
      end
      ST_T_RYTX: begin
        op        = mer_pkg::OP_T_RYTX;
        state_nxt = ST_T_TY2;
      end
      ST_T_TY2: begin
        op        = mer_pkg::OP_T_TY2;
        state_nxt = ST_T_RXTY;
      end
      ST_T_RXTY: begin
        op        = mer_pkg::OP_T_RXTY;
        state_nxt = ST_T_RXRY;
      end
      ST_T_RXRY: begin
        op        = mer_pkg::OP_T_RXRY;
        state_nxt = ST_T_FIN;
      end
      ST_T_FIN: begin
        op        = mer_pkg::OP_T_FIN;
        state_nxt = ST_R2_STEP;
      end
      ST_R2_STEP: begin
        op        = mer_pkg::OP_R2_STEP;
        state_nxt = ST_R2_UPD;
      end
      ST_R2_UPD: begin
        op        = mer_pkg::OP_R2_UPD;
        state_nxt = ST_R2_FIN;
      end
      ST_R2_FIN: begin
        op        = mer_pkg::OP_R2_FIN;
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) begin
          op        = mer_pkg::OP_EMIT;
          emit      = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      ST_EMIT_NULL: begin
        if (out_free) begin
          op        = mer_pkg::OP_EMIT_NULL;
          emit      = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Set valid on a new result, drop it once taken
  always_comb begin
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ----- src/mer_datapath.sv -----
module mer_datapath #(
  parameter int COORD_BITS  = 10,
  parameter int RADIUS_BITS = 9,
  parameter int PIX_W       = COORD_BITS + 2
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  mer_pkg::mer_op_t        op,
  input  logic [COORD_BITS-1:0]   in_center_x,
  input  logic [COORD_BITS-1:0]   in_center_y,
  input  logic [RADIUS_BITS-1:0]  in_radius_x,
  input  logic [RADIUS_BITS-1:0]  in_radius_y,
  output mer_pkg::mer_status_t    status,
  output logic                    res_valid,
  output logic                    res_last,
  output logic [8*PIX_W-1:0]      res_pix
);

  localparam int OFF_W  = RADIUS_BITS + 1;
  localparam int RSQ_W  = 2 * RADIUS_BITS;
  localparam int MA_W   = 2 * RADIUS_BITS;
  localparam int MB_W   = 2 * RADIUS_BITS + 4;
  localparam int PROD_W = MA_W + MB_W;
  localparam int DEC_W  = 4 * RADIUS_BITS + 8;
  localparam int EXT_W  = (PIX_W > OFF_W) ? PIX_W : OFF_W;

  logic [COORD_BITS-1:0]    cx_r, cx_nxt;
  logic [COORD_BITS-1:0]    cy_r, cy_nxt;
  logic [OFF_W-1:0]         x_r, x_nxt;
  logic [OFF_W-1:0]         y_r, y_nxt;
  logic [RSQ_W-1:0]         rx2_r, rx2_nxt;
  logic [RSQ_W-1:0]         ry2_r, ry2_nxt;
  logic [PROD_W-1:0]        t_r, t_nxt;
  logic [PROD_W-1:0]        p_r, p_nxt;
  logic signed [DEC_W-1:0]  dec_r, dec_nxt;
  logic                     flag_r, flag_nxt;
  logic                     busy_r, busy_nxt;
  logic                     reg2_r, reg2_nxt;
  logic                     res_valid_r, res_valid_nxt;
  logic                     res_last_r, res_last_nxt;
  logic [8*PIX_W-1:0]       res_pix_r, res_pix_nxt;

  logic [MA_W-1:0]          mul_a;
  logic [MB_W-1:0]          mul_b;
  logic signed [DEC_W-1:0]  p_e, rx2_e, ry2_e;
  logic [OFF_W-1:0]         x_inc, y_dec;
  logic [OFF_W:0]           tx;
  logic                     dec_neg, dec_pos;
  logic [EXT_W-1:0]         cx_e, cy_e, x_e, y_e;
  logic [EXT_W-1:0]         sx_p, sx_m, sy_p, sy_m;
  logic [8*PIX_W-1:0]       pix_now;

  // Shared multiplier, product registered every cycle
  assign p_nxt = PROD_W'(mul_a) * PROD_W'(mul_b);

  assign p_e     = $signed({{(DEC_W-PROD_W){1'b0}}, p_r});
  assign rx2_e   = $signed({{(DEC_W-RSQ_W){1'b0}}, rx2_r});
  assign ry2_e   = $signed({{(DEC_W-RSQ_W){1'b0}}, ry2_r});
  assign x_inc   = x_r + 1'b1;
  assign y_dec   = y_r - 1'b1;
  assign tx      = {x_r, 1'b1};
  assign dec_neg = dec_r[DEC_W-1];
  assign dec_pos = !dec_r[DEC_W-1] && (dec_r != '0);

  // Mirror the offset into four pixels, wrapped to the pixel width
  assign cx_e = EXT_W'(cx_r);
  assign cy_e = EXT_W'(cy_r);
  assign x_e  = EXT_W'(x_r);
  assign y_e  = EXT_W'(y_r);
  assign sx_p = cx_e + x_e;
  assign sx_m = cx_e - x_e;
  assign sy_p = cy_e + y_e;
  assign sy_m = cy_e - y_e;
  assign pix_now = {sy_m[PIX_W-1:0], sx_m[PIX_W-1:0],
                    sy_m[PIX_W-1:0], sx_p[PIX_W-1:0],
                    sy_p[PIX_W-1:0], sx_m[PIX_W-1:0],
                    sy_p[PIX_W-1:0], sx_p[PIX_W-1:0]};

  // Decode the command: operand select and register updates
  always_comb begin
    cx_nxt        = cx_r;
    cy_nxt        = cy_r;
    x_nxt         = x_r;
    y_nxt         = y_r;
    rx2_nxt       = rx2_r;
    ry2_nxt       = ry2_r;
    t_nxt         = t_r;
    dec_nxt       = dec_r;
    flag_nxt      = flag_r;
    busy_nxt      = busy_r;
    reg2_nxt      = reg2_r;
    res_valid_nxt = res_valid_r;
    res_last_nxt  = res_last_r;
    res_pix_nxt   = res_pix_r;
    mul_a         = '0;
    mul_b         = '0;
    unique case (op)
      mer_pkg::OP_NOP: begin
      end
      mer_pkg::OP_LOAD: begin
        cx_nxt   = in_center_x;
        cy_nxt   = in_center_y;
        x_nxt    = '0;
        y_nxt    = OFF_W'(in_radius_y);
        reg2_nxt = 1'b0;
        mul_a    = MA_W'(in_radius_x);
        mul_b    = MB_W'(in_radius_x);
      end
      mer_pkg::OP_SQ_RY: begin
        rx2_nxt = p_r[RSQ_W-1:0];
        mul_a   = MA_W'(y_r);
        mul_b   = MB_W'(y_r);
      end
      mer_pkg::OP_RXRY: begin
        ry2_nxt = p_r[RSQ_W-1:0];
        mul_a   = MA_W'(rx2_r);
        mul_b   = MB_W'(y_r);
      end
      mer_pkg::OP_DEC0: begin
        dec_nxt = (ry2_e <<< 2) - (p_e <<< 2) + rx2_e;
      end
      mer_pkg::OP_R1_MX: begin
        mul_a = MA_W'(ry2_r);
        mul_b = MB_W'(x_r);
      end
      mer_pkg::OP_R1_MY: begin
        t_nxt = p_r;
        mul_a = MA_W'(rx2_r);
        mul_b = MB_W'(y_r);
      end
      mer_pkg::OP_R1_CMP: begin
        mul_a = MA_W'(ry2_r);
        mul_b = MB_W'(x_inc);
        if (t_r < p_r) begin
          x_nxt    = x_inc;
          flag_nxt = dec_neg;
          if (!dec_neg) begin
            y_nxt = y_dec;
          end
        end
      end
      mer_pkg::OP_R1_UPD: begin
        dec_nxt = dec_r + (p_e <<< 3) + (ry2_e <<< 2);
        mul_a   = MA_W'(rx2_r);
        mul_b   = MB_W'(y_r);
      end
      mer_pkg::OP_R1_FIN: begin
        if (!flag_r) begin
          dec_nxt = dec_r - (p_e <<< 3);
        end
      end
      mer_pkg::OP_T_TX2: begin
        mul_a = MA_W'(tx);
        mul_b = MB_W'(tx);
      end
      mer_pkg::OP_T_RYTX: begin
        mul_a = MA_W'(ry2_r);
        mul_b = p_r[MB_W-1:0];
      end
      mer_pkg::OP_T_TY2: begin
        dec_nxt = p_e;
        mul_a   = MA_W'(y_dec);
        mul_b   = MB_W'(y_dec);
      end
      mer_pkg::OP_T_RXTY: begin
        mul_a = MA_W'(rx2_r);
        mul_b = p_r[MB_W-1:0];
      end
      mer_pkg::OP_T_RXRY: begin
        dec_nxt = dec_r + (p_e <<< 2);
        mul_a   = MA_W'(rx2_r);
        mul_b   = MB_W'(ry2_r);
      end
      mer_pkg::OP_T_FIN: begin
        dec_nxt  = dec_r - (p_e <<< 2);
        reg2_nxt = 1'b1;
      end
      mer_pkg::OP_R2_STEP: begin
        y_nxt    = y_dec;
        flag_nxt = dec_pos;
        if (!dec_pos) begin
          x_nxt = x_inc;
        end
        mul_a = MA_W'(rx2_r);
        mul_b = MB_W'(y_dec);
      end
      mer_pkg::OP_R2_UPD: begin
        dec_nxt = dec_r + (rx2_e <<< 2) - (p_e <<< 3);
        mul_a   = MA_W'(ry2_r);
        mul_b   = MB_W'(x_r);
      end
      mer_pkg::OP_R2_FIN: begin
        if (!flag_r) begin
          dec_nxt = dec_r + (p_e <<< 3);
        end
      end
      mer_pkg::OP_EMIT: begin
        res_valid_nxt = 1'b1;
        res_last_nxt  = (y_r == '0);
        res_pix_nxt   = pix_now;
        busy_nxt      = (y_r != '0);
      end
      mer_pkg::OP_EMIT_NULL: begin
        res_valid_nxt = 1'b0;
        res_last_nxt  = 1'b0;
        res_pix_nxt   = '0;
      end
      default: begin
      end
    endcase
  end

  // Hold walk control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      reg2_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      reg2_r <= reg2_nxt;
    end
  end

  // Hold payload registers
  always_ff @(posedge clk) begin
    cx_r        <= cx_nxt;
    cy_r        <= cy_nxt;
    x_r         <= x_nxt;
    y_r         <= y_nxt;
    rx2_r       <= rx2_nxt;
    ry2_r       <= ry2_nxt;
    t_r         <= t_nxt;
    p_r         <= p_nxt;
    dec_r       <= dec_nxt;
    flag_r      <= flag_nxt;
    res_valid_r <= res_valid_nxt;
    res_last_r  <= res_last_nxt;
    res_pix_r   <= res_pix_nxt;
  end

  assign status.busy       = busy_r;
  assign status.region_two = reg2_r;
  assign status.lt         = (t_r < p_r);

  assign res_valid = res_valid_r;
  assign res_last  = res_last_r;
  assign res_pix   = res_pix_r;

endmodule

// ----- src/mer_checker.sv -----
module mer_checker #(
  parameter int COORD_BITS = 10
) (
  input logic                                   clk,
  input logic                                   rst_n,
  input logic                                   in_tvalid,
  input logic                                   in_tready,
  input logic                                   out_tvalid,
  input logic                                   out_tready,
  input logic [((8*(COORD_BITS+2)+7)/8)*8-1:0]  out_tdata,
  input logic                                   out_tuser,
  input logic                                   out_tlast
);

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=>
      out_tvalid && $stable(out_tdata) && $stable(out_tuser) && $stable(out_tlast))
    else $error("result changed while stalled");

  // One item in flight: input closes right after an accept
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input accepted back to back");

  // Final step is always a meaningful result
  a_last_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> out_tuser)
    else $error("last flagged on an empty result");

  // Empty result carries all-zero pixels
  a_null_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> (out_tdata == '0))
    else $error("empty result carries pixel data");

  // Reset empties the output
  a_rst_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

endmodule

bind midpoint_ellipse_rasterizer_top mer_checker #(
  .COORD_BITS (COORD_BITS)
) u_mer_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);
